### rtl/homography_inlier_test_assert.svh
// Assertion macros shared by the homography inlier test RTL.
`ifndef HOMOGRAPHY_INLIER_TEST_ASSERT_SVH
`define HOMOGRAPHY_INLIER_TEST_ASSERT_SVH
`ifndef SYNTH
`define HIT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define HIT_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define HIT_ASSERT(label, clk, rst_n, prop)
`define HIT_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

### rtl/hit_pkg.sv
// Types and constants of the homography inlier test.
package hit_pkg;
    localparam int CoordBits = 16;
    localparam int CoefBits  = 32;
    localparam int TagBits   = 16;
    localparam int MagBits   = 51;
    localparam int QuoBits   = 32;
    localparam int DivLat    = QuoBits + 1;
    localparam int DiffBits  = 21;

    typedef enum logic [2:0] {
        REG_ROW0_AB      = 3'd0,
        REG_ROW0C_ROW1A  = 3'd1,
        REG_ROW1_BC      = 3'd2,
        REG_ROW2_AB      = 3'd3,
        REG_ROW2_C       = 3'd4,
        REG_THRESHOLD    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [TagBits-1:0]   tag;
        logic [CoordBits-1:0] tx;
        logic [CoordBits-1:0] ty;
        logic                 negx;
        logic                 negy;
        logic                 degen;
    } side_t;
endpackage

### rtl/hit_div.sv
// Pipelined restoring divider giving a capped Q.8 quotient of two magnitudes.
module hit_div
    import hit_pkg::*;
(
    input  logic               clk,
    input  logic [MagBits-1:0] num,
    input  logic [MagBits-1:0] den,
    output logic [QuoBits:0]   quo
);
    localparam int NumBits = MagBits + 8;

    logic [NumBits-1:0] rem_reg [0:QuoBits];
    logic [MagBits-1:0] den_reg [0:QuoBits];
    logic [QuoBits-1:0] q_reg   [0:QuoBits];
    logic               cap_reg [0:QuoBits];

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= {num, 8'd0};
        den_reg[0] <= den;
        q_reg[0]   <= '0;
        cap_reg[0] <= ({24'd0, num} >= {den, 24'd0});
    end

    for (genvar k = 0; k < QuoBits; k++) begin : g_stage
        localparam int Sh = QuoBits - 1 - k;
        logic ge;
        logic [NumBits-1:0] rem_next;
        assign ge = (rem_reg[k] >> Sh) >= {8'd0, den_reg[k]};
        assign rem_next = ge ? rem_reg[k] - ({8'd0, den_reg[k]} << Sh) : rem_reg[k];
        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= rem_next;
            den_reg[k+1] <= den_reg[k];
            q_reg[k+1]   <= {q_reg[k][QuoBits-2:0], ge};
            cap_reg[k+1] <= cap_reg[k];
        end
    end

    assign quo = cap_reg[QuoBits] ? {1'b1, {QuoBits{1'b0}}} : {1'b0, q_reg[QuoBits]};
endmodule

### rtl/homography_inlier_test.sv
// Top level of the homography reprojection inlier test pipeline.
// One point pair is taken in every clock cycle and busy is always low. Each result
// appears with done for one cycle, in input order; the receiver cannot stall. Each
// result passes through product, sum, magnitude, the 33-stage quotient pipeline,
// difference, square and compare stages. Configuration writes take effect at once
// and are to be made by the user only while idle; the block does not enforce this.
module homography_inlier_test
    import hit_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [15:0]          match_tag,
    input  logic [15:0]          query_x,
    input  logic [15:0]          query_y,
    input  logic [15:0]          templ_x,
    input  logic [15:0]          templ_y,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_idx,
    input  logic [63:0]          cfg_wdata,
    output logic                 done,
    output logic [15:0]          tag_out,
    output logic                 is_inlier,
    output logic                 degenerate,
    output logic [31:0]          sq_error
);
`include "homography_inlier_test_assert.svh"

    logic [63:0] r0_reg, r1_reg, r2_reg, r3_reg;
    logic [31:0] r4_reg;
    logic [15:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r0_reg  <= 64'h0001_0000_0000_0000;
            r1_reg  <= '0;
            r2_reg  <= 64'h0001_0000_0000_0000;
            r3_reg  <= '0;
            r4_reg  <= 32'h0001_0000;
            thr_reg <= 16'd768;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_idx))
                REG_ROW0_AB:     r0_reg  <= cfg_wdata;
                REG_ROW0C_ROW1A: r1_reg  <= cfg_wdata;
                REG_ROW1_BC:     r2_reg  <= cfg_wdata;
                REG_ROW2_AB:     r3_reg  <= cfg_wdata;
                REG_ROW2_C:      r4_reg  <= cfg_wdata[31:0];
                REG_THRESHOLD:   thr_reg <= cfg_wdata[15:0];
                default:         ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage 1: products.
    logic signed [48:0] p00_reg, p01_reg, p10_reg, p11_reg, p20_reg, p21_reg;
    logic [15:0] tag1_reg, tx1_reg, ty1_reg;
    logic        v1_reg;
    logic signed [16:0] qx, qy;
    assign qx = $signed({1'b0, query_x});
    assign qy = $signed({1'b0, query_y});

    always_ff @(posedge clk)
    begin
        p00_reg  <= $signed(r0_reg[63:32]) * qx;
        p01_reg  <= $signed(r0_reg[31:0]) * qy;
        p10_reg  <= $signed(r1_reg[31:0]) * qx;
        p11_reg  <= $signed(r2_reg[63:32]) * qy;
        p20_reg  <= $signed(r3_reg[63:32]) * qx;
        p21_reg  <= $signed(r3_reg[31:0]) * qy;
        tag1_reg <= match_tag;
        tx1_reg  <= templ_x;
        ty1_reg  <= templ_y;
    end

    // Stage 2: numerators and denominator.
    logic signed [MagBits-1:0] nx_reg, ny_reg, d_reg;
    logic [15:0] tag2_reg, tx2_reg, ty2_reg;
    logic        v2_reg;

    always_ff @(posedge clk)
    begin
        nx_reg <= MagBits'(p00_reg) + MagBits'(p01_reg)
                  + MagBits'($signed({r1_reg[63:32], 4'd0}));
        ny_reg <= MagBits'(p10_reg) + MagBits'(p11_reg)
                  + MagBits'($signed({r2_reg[31:0], 4'd0}));
        d_reg  <= MagBits'(p20_reg) + MagBits'(p21_reg)
                  + MagBits'($signed({r4_reg, 4'd0}));
        tag2_reg <= tag1_reg;
        tx2_reg  <= tx1_reg;
        ty2_reg  <= ty1_reg;
    end

    // Stage 3: magnitudes and signs.
    logic [MagBits-1:0] mx_reg, my_reg, md_reg;
    side_t side_reg [0:DivLat];
    logic  vs_reg [0:DivLat];

    always_ff @(posedge clk)
    begin
        mx_reg <= nx_reg[MagBits-1] ? MagBits'(-nx_reg) : MagBits'(nx_reg);
        my_reg <= ny_reg[MagBits-1] ? MagBits'(-ny_reg) : MagBits'(ny_reg);
        md_reg <= d_reg[MagBits-1] ? MagBits'(-d_reg) : MagBits'(d_reg);
        side_reg[0].tag   <= tag2_reg;
        side_reg[0].tx    <= tx2_reg;
        side_reg[0].ty    <= ty2_reg;
        side_reg[0].negx  <= nx_reg[MagBits-1] != d_reg[MagBits-1];
        side_reg[0].negy  <= ny_reg[MagBits-1] != d_reg[MagBits-1];
        side_reg[0].degen <= (d_reg == '0);
        for (int k = 0; k < DivLat; k++)
        begin
            side_reg[k+1] <= side_reg[k];
        end
    end

    logic [QuoBits:0] qx_div, qy_div;
    hit_div u_div_x (.clk(clk), .num(mx_reg), .den(md_reg), .quo(qx_div));
    hit_div u_div_y (.clk(clk), .num(my_reg), .den(md_reg), .quo(qy_div));

    // Stage 4: signed differences, clamped.
    side_t sd;
    logic signed [QuoBits+2:0] ux, uy, ex, ey;
    logic signed [DiffBits-1:0] dx_reg, dy_reg;
    logic [15:0] tag4_reg, tag5_reg;
    logic        dg4_reg, dg5_reg, v4_reg, v5_reg;
    localparam logic signed [QuoBits+2:0] DCap = 35'sd1048576;

    assign sd = side_reg[DivLat];
    assign ux = sd.negx ? -$signed({2'b00, qx_div}) : $signed({2'b00, qx_div});
    assign uy = sd.negy ? -$signed({2'b00, qy_div}) : $signed({2'b00, qy_div});
    assign ex = ux - $signed({15'd0, sd.tx, 4'd0});
    assign ey = uy - $signed({15'd0, sd.ty, 4'd0});

    always_ff @(posedge clk)
    begin
        dx_reg <= (ex > DCap) ? DiffBits'(DCap) : (ex < -DCap) ? DiffBits'(-DCap)
                  : DiffBits'(ex);
        dy_reg <= (ey > DCap) ? DiffBits'(DCap) : (ey < -DCap) ? DiffBits'(-DCap)
                  : DiffBits'(ey);
        tag4_reg <= sd.tag;
        dg4_reg  <= sd.degen;
    end

    // Stage 5: squares.
    logic [40:0] sqx_reg, sqy_reg;
    logic signed [2*DiffBits-1:0] sqx_full, sqy_full;
    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;

    always_ff @(posedge clk)
    begin
        sqx_reg  <= sqx_full[40:0];
        sqy_reg  <= sqy_full[40:0];
        tag5_reg <= tag4_reg;
        dg5_reg  <= dg4_reg;
    end

    // Stage 6: sum, compare and saturate.
    logic [41:0] sum;
    logic [31:0] thr2;
    assign sum  = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign thr2 = thr_reg * thr_reg;

    logic        done_reg, inl_reg, dgo_reg;
    logic [15:0] tago_reg;
    logic [31:0] err_reg;

    always_ff @(posedge clk)
    begin
        tago_reg <= tag5_reg;
        dgo_reg  <= dg5_reg;
        inl_reg  <= !dg5_reg && (sum < {10'd0, thr2});
        err_reg  <= (dg5_reg || sum[41:40] != 2'b00) ? 32'hFFFF_FFFF : sum[39:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
            for (int k = 0; k <= DivLat; k++)
            begin
                vs_reg[k] <= 1'b0;
            end
        end
        else
        begin
            v1_reg    <= start && !busy;
            v2_reg    <= v1_reg;
            vs_reg[0] <= v2_reg;
            for (int k = 0; k < DivLat; k++)
            begin
                vs_reg[k+1] <= vs_reg[k];
            end
            v4_reg   <= vs_reg[DivLat];
            v5_reg   <= v4_reg;
            done_reg <= v5_reg;
        end
    end

    assign done       = done_reg;
    assign tag_out    = tago_reg;
    assign is_inlier  = inl_reg;
    assign degenerate = dgo_reg;
    assign sq_error   = err_reg;

    `HIT_ASSERT_NEVER(a_never_busy, clk, rst_n, busy)
    `HIT_ASSERT(a_degen_no_inlier, clk, rst_n, (done && degenerate) |-> (!is_inlier && sq_error == 32'hFFFF_FFFF))
    `HIT_ASSERT(a_inlier_small, clk, rst_n, (done && is_inlier) |-> (sq_error != 32'hFFFF_FFFF))
    `HIT_ASSERT(a_done_follows, clk, rst_n, done |-> $past(v5_reg))
endmodule
